// File: sv/rle_pkg.sv
// Shared types, codes and helpers for the Raft leader election node.
// Used by rle_div and raft_leader_election_node_top. No dependencies.
`timescale 1ns / 1ps

package rle_pkg;

  localparam int DEF_MAX_NODES = 8;
  localparam int DEF_TERM_BITS = 32;
  localparam int MAX_RESULTS   = 7;
  localparam int DIV_W         = 16;   // LFSR / timeout width
  localparam int SZ_W          = 5;    // width for cluster size math

  typedef enum logic [1:0] {
    ROLE_FOLLOWER  = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER    = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    MSG_VOTE_REQ     = 2'd0,
    MSG_VOTE_REPLY   = 2'd1,
    MSG_APPEND       = 2'd2,
    MSG_APPEND_REPLY = 2'd3
  } msg_t;

  typedef enum logic [2:0] {
    REG_NODE_ID      = 3'd0,
    REG_CLUSTER_SIZE = 3'd1,
    REG_HEARTBEAT_MS = 3'd2,
    REG_TIMEOUT_MIN  = 3'd3,
    REG_TIMEOUT_SPAN = 3'd4,
    REG_RANDOM_SEED  = 3'd5,
    REG_NODE_ALIVE   = 3'd6
  } cfg_reg_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MSG  = 1'b1;

  localparam logic [2:0]       RST_NODE_ID      = 3'd0;
  localparam logic [3:0]       RST_CLUSTER_SIZE = 4'd3;
  localparam logic [DIV_W-1:0] RST_HEARTBEAT_MS = 16'd50;
  localparam logic [DIV_W-1:0] RST_TIMEOUT_MIN  = 16'd150;
  localparam logic [DIV_W-1:0] RST_TIMEOUT_SPAN = 16'd150;
  localparam logic [DIV_W-1:0] RST_RANDOM_SEED  = 16'd1;

  localparam logic [DIV_W-1:0] LFSR_TAPS = 16'hB400;

  // One Galois step; zero is replaced by one.
  function automatic logic [DIV_W-1:0] lfsr_adv(input logic [DIV_W-1:0] v);
    logic [DIV_W-1:0] n;
    n = {1'b0, v[DIV_W-1:1]};
    if (v[0]) n = n ^ LFSR_TAPS;
    if (n == '0) n = DIV_W'(1);
    return n;
  endfunction

endpackage

// File: sv/raft_leader_election_node_top.sv
// Raft leader election node. An accepted item is decided in S_EXEC; an item that draws a
// new election timeout then waits in S_DIV for the bit-serial modulo unit. Results follow
// one per free output cycle; the broadcast walk also spends a step on own id, one where a
// broadcast is followed by a second, and one before idle. in_ready and cfg_ready only while
// idle.
// Reset (rst, synchronous): follower, term 0, no vote, registers at defaults.
`timescale 1ns / 1ps

module raft_leader_election_node_top #(
  parameter int MAX_NODES = rle_pkg::DEF_MAX_NODES,
  parameter int TERM_BITS = rle_pkg::DEF_TERM_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [1:0]  msg_type,
  input  logic [31:0] msg_term,
  input  logic [2:0]  msg_from,
  input  logic [2:0]  msg_candidate,
  input  logic        msg_flag,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_type,
  output logic [2:0]  out_to,
  output logic [31:0] out_term,
  output logic [2:0]  out_candidate,
  output logic        out_flag,
  output logic        last,
  output logic [1:0]  role,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rle_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;

  // configuration registers
  logic [2:0]       node_id;
  logic [3:0]       cluster_size;
  logic [DIV_W-1:0] heartbeat_ms;
  logic [DIV_W-1:0] timeout_min;
  logic [DIV_W-1:0] timeout_span;
  logic             node_alive;

  // node state
  role_t            node_role;
  logic [TERM_BITS-1:0] current_term;
  logic             vote_valid;
  logic [2:0]       vote_id;
  logic [3:0]       votes_counted;
  logic [DIV_W-1:0] elapsed_ticks;
  logic [DIV_W:0]   election_timeout;
  logic [DIV_W-1:0] lfsr;

  // captured item
  logic                 m_op;
  msg_t                 m_type;
  logic [TERM_BITS-1:0] m_term;
  logic [2:0]           m_from;
  logic [2:0]           m_cand;
  logic                 m_flag;

  // emit plan
  logic       plan_req;
  logic       plan_app;
  msg_t       rep_type;
  logic       rep_flag;
  logic [2:0] total;
  logic [2:0] emitted;
  logic [IDX_W-1:0] idx;

  // modulo unit
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_rem;

  // cluster size arithmetic
  logic [SZ_W-1:0] size_raw;
  logic [SZ_W-1:0] eff_size;
  logic [SZ_W-1:0] half_size;
  logic [SZ_W-1:0] node5;
  logic [SZ_W-1:0] idx5;
  logic            own_in;
  logic            known;
  logic [SZ_W:0]   n_bcast;

  always_comb begin
    size_raw = {1'b0, cluster_size};
    if (size_raw == '0) eff_size = SZ_W'(1);
    else if (size_raw > SZ_W'(MAX_NODES)) eff_size = SZ_W'(MAX_NODES);
    else eff_size = size_raw;
    half_size = eff_size >> 1;
    node5     = SZ_W'(node_id);
    idx5      = SZ_W'(idx);
    own_in    = (node5 < eff_size);
    known     = (SZ_W'(m_from) < eff_size);
    n_bcast   = (SZ_W+1)'(eff_size) - (SZ_W+1)'(own_in);
  end

  // decide: next state of the node for the captured item
  role_t                x_role;
  logic [TERM_BITS-1:0] x_term;
  logic                 x_vv;
  logic [2:0]           x_vid;
  logic [3:0]           x_votes;
  logic [DIV_W-1:0]     x_elapsed;
  logic [1:0]           x_draws;
  logic                 x_req;
  logic                 x_app;
  logic                 x_reply;
  msg_t                 x_rtype;
  logic                 x_rflag;
  logic [DIV_W-1:0]     x_lfsr;
  logic [SZ_W+1:0]      x_count;
  logic [2:0]           x_total;

  logic [DIV_W-1:0]     elapsed_inc;
  logic [DIV_W-1:0]     lim;
  logic [TERM_BITS-1:0] term_inc;
  logic [3:0]           votes_inc;
  logic                 higher;
  logic                 same;
  logic                 ge;
  role_t                role1;
  logic                 vv1;
  logic [2:0]           vid1;

  always_comb begin
    elapsed_inc = (elapsed_ticks != '1) ? elapsed_ticks + DIV_W'(1) : elapsed_ticks;
    lim         = election_timeout[DIV_W] ? '1 : election_timeout[DIV_W-1:0];
    term_inc    = (current_term != '1) ? current_term + TERM_BITS'(1) : current_term;
    votes_inc   = (votes_counted != 4'hF) ? votes_counted + 4'd1 : votes_counted;
    higher      = (m_term > current_term);
    same        = (m_term == current_term);
    ge          = higher | same;
    role1       = higher ? ROLE_FOLLOWER : node_role;
    vv1         = higher ? 1'b0 : vote_valid;
    vid1        = higher ? 3'd0 : vote_id;

    x_role    = node_role;
    x_term    = current_term;
    x_vv      = vote_valid;
    x_vid     = vote_id;
    x_votes   = votes_counted;
    x_elapsed = elapsed_ticks;
    x_draws   = 2'd0;
    x_req     = 1'b0;
    x_app     = 1'b0;
    x_reply   = 1'b0;
    x_rtype   = MSG_VOTE_REPLY;
    x_rflag   = 1'b0;

    if (m_op == OP_TICK) begin
      if (node_role == ROLE_LEADER) begin
        if (elapsed_inc >= heartbeat_ms) begin
          x_app     = 1'b1;
          x_elapsed = '0;
        end else begin
          x_elapsed = elapsed_inc;
        end
      end else if (elapsed_inc >= lim) begin
        // timeout: new candidate, own vote counted
        x_role    = ROLE_CANDIDATE;
        x_term    = term_inc;
        x_vv      = 1'b1;
        x_vid     = node_id;
        x_votes   = 4'd1;
        x_draws   = 2'd1;
        x_elapsed = '0;
        x_req     = 1'b1;
        if (SZ_W'(1) > half_size) begin
          x_role = ROLE_LEADER;
          x_app  = 1'b1;
        end
      end else begin
        x_elapsed = elapsed_inc;
      end
    end else begin
      if (higher) begin
        x_role    = ROLE_FOLLOWER;
        x_term    = m_term;
        x_vv      = 1'b0;
        x_vid     = 3'd0;
        x_draws   = 2'd1;
        x_elapsed = '0;
      end
      unique case (m_type)
        MSG_VOTE_REQ: begin
          if (ge && (!vv1 || vid1 == m_cand)) begin
            x_vv      = 1'b1;
            x_vid     = m_cand;
            x_draws   = x_draws + 2'd1;
            x_elapsed = '0;
            x_rflag   = 1'b1;
          end
          x_reply = known;
          x_rtype = MSG_VOTE_REPLY;
        end
        MSG_VOTE_REPLY: begin
          if (role1 == ROLE_CANDIDATE && same && m_flag) begin
            x_votes = votes_inc;
            if (SZ_W'(votes_inc) > half_size) begin
              x_role    = ROLE_LEADER;
              x_elapsed = '0;
              x_app     = 1'b1;
            end
          end
        end
        MSG_APPEND: begin
          if (ge) begin
            x_rflag = 1'b1;
            if (role1 == ROLE_CANDIDATE) x_role = ROLE_FOLLOWER;
            x_draws   = x_draws + 2'd1;
            x_elapsed = '0;
          end
          x_reply = known;
          x_rtype = MSG_APPEND_REPLY;
        end
        MSG_APPEND_REPLY: begin
          // only the term matters
        end
      endcase
    end

    unique case (x_draws)
      2'd0:    x_lfsr = lfsr;
      2'd1:    x_lfsr = lfsr_adv(lfsr);
      default: x_lfsr = lfsr_adv(lfsr_adv(lfsr));
    endcase

    x_count = (x_req ? (SZ_W+2)'(n_bcast) : '0) + (x_app ? (SZ_W+2)'(n_bcast) : '0)
              + (SZ_W+2)'(x_reply);
    x_total = (x_count > (SZ_W+2)'(MAX_RESULTS)) ? 3'(MAX_RESULTS) : x_count[2:0];
  end

  rle_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lfsr),
    .divisor  ({1'b0, timeout_span} + (DIV_W+1)'(1)),
    .done     (div_done),
    .rem      (div_rem)
  );

  // a register write pending while idle goes ahead of the next item
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  logic slot_free;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      node_id          <= RST_NODE_ID;
      cluster_size     <= RST_CLUSTER_SIZE;
      heartbeat_ms     <= RST_HEARTBEAT_MS;
      timeout_min      <= RST_TIMEOUT_MIN;
      timeout_span     <= RST_TIMEOUT_SPAN;
      node_alive       <= 1'b1;
      node_role        <= ROLE_FOLLOWER;
      current_term     <= '0;
      vote_valid       <= 1'b0;
      vote_id          <= 3'd0;
      votes_counted    <= 4'd0;
      elapsed_ticks    <= '0;
      election_timeout <= {1'b0, RST_TIMEOUT_MIN};
      lfsr             <= RST_RANDOM_SEED;
      plan_req         <= 1'b0;
      plan_app         <= 1'b0;
      total            <= 3'd0;
      emitted          <= 3'd0;
      idx              <= '0;
      div_start        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            m_op   <= operation;
            m_type <= msg_t'(msg_type);
            m_term <= TERM_BITS'(msg_term);
            m_from <= msg_from;
            m_cand <= msg_candidate;
            m_flag <= msg_flag;
            // a dead node swallows the item
            if (node_alive) state <= S_EXEC;
          end
        end
        S_EXEC: begin
          node_role     <= x_role;
          current_term  <= x_term;
          vote_valid    <= x_vv;
          vote_id       <= x_vid;
          votes_counted <= x_votes;
          elapsed_ticks <= x_elapsed;
          lfsr          <= x_lfsr;
          plan_req      <= x_req;
          plan_app      <= x_app;
          rep_type      <= x_rtype;
          rep_flag      <= x_rflag;
          total         <= x_total;
          emitted       <= 3'd0;
          idx           <= '0;
          if (x_draws != 2'd0) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end else if (x_total != 3'd0) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            election_timeout <= {1'b0, timeout_min} + {1'b0, div_rem};
            state            <= (total != 3'd0) ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (emitted == total) begin
              state <= S_IDLE;
            end else if (plan_req || plan_app) begin
              // walk ids below the cluster size, skipping our own
              if (idx5 == eff_size) begin
                if (plan_req) plan_req <= 1'b0;
                else plan_app <= 1'b0;
                idx <= '0;
              end else begin
                idx <= idx + IDX_W'(1);
                if (idx5 != node5) begin
                  out_valid     <= 1'b1;
                  out_type      <= plan_req ? MSG_VOTE_REQ : MSG_APPEND;
                  out_to        <= 3'(idx5);
                  out_term      <= 32'(current_term);
                  out_candidate <= plan_req ? node_id : 3'd0;
                  out_flag      <= 1'b0;
                  last          <= (emitted + 3'd1 == total);
                  role          <= node_role;
                  emitted       <= emitted + 3'd1;
                end
              end
            end else begin
              out_valid     <= 1'b1;
              out_type      <= rep_type;
              out_to        <= m_from;
              out_term      <= 32'(current_term);
              out_candidate <= 3'd0;
              out_flag      <= rep_flag;
              last          <= (emitted + 3'd1 == total);
              role          <= node_role;
              emitted       <= emitted + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // register writes arrive only while idle
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NODE_ID:      node_id      <= cfg_data[2:0];
          REG_CLUSTER_SIZE: cluster_size <= cfg_data[3:0];
          REG_HEARTBEAT_MS: heartbeat_ms <= cfg_data;
          REG_TIMEOUT_MIN: begin
            timeout_min      <= cfg_data;
            election_timeout <= {1'b0, cfg_data};
          end
          REG_TIMEOUT_SPAN: timeout_span <= cfg_data;
          REG_RANDOM_SEED:  lfsr <= (cfg_data != '0) ? cfg_data : DIV_W'(1);
          REG_NODE_ALIVE:   node_alive   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sv/rle_div.sv
// Bit-serial restoring modulo unit: remainder of dividend by divisor.
// Depends on rle_pkg (DIV_W). One quotient bit per cycle.
`timescale 1ns / 1ps

module rle_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rle_pkg::DIV_W-1:0] dividend,
  input  logic [rle_pkg::DIV_W:0]   divisor,
  output logic                      done,
  output logic [rle_pkg::DIV_W-1:0] rem
);
  import rle_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] acc;
  logic [DIV_W-1:0] dq;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  // acc stays below divisor, so trial fits DIV_W+1 bits
  always_comb begin
    trial = {acc, dq[DIV_W-1]};
    fits  = (trial >= divisor);
    diff  = trial - divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc <= '0;
        dq  <= dividend;
        cnt <= CNT_W'(DIV_W);
      end else if (cnt != '0) begin
        acc <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dq  <= {dq[DIV_W-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  assign rem = acc;

endmodule
